/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Implication checked on the next edge.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* rtl/core/wtc_pkg.sv */
// ----------------------------------------------------------------------------
// Word table package
// Request and response types and status codes of the word table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wtc_pkg;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] STAT_NEW      = 2'd0;
  localparam logic [1:0] STAT_FOUND    = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  localparam logic [7:0] FREQ_MAX = 8'd255;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic       last_char;
    logic [7:0] category;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] entry_index;
    logic [7:0] frequency;
    logic [7:0] entry_category;
    logic [6:0] entry_count;
  } rsp_t;

endpackage

/* rtl/core/word_table_insert_count_lookup.sv */
// ----------------------------------------------------------------------------
// Word table with insert-or-count and lookup
// Builds words from character requests and adds, counts or looks them up
// in a table of up to ENTRIES words.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                      Moves
//   request   req_valid, req_stall, req    one character, command on last
//   response  rsp_valid, rsp_stall, rsp    one result per finished word
//
// A character request is taken whenever it is not stalled; the front end stalls only
// while both slots of the command queue hold finished words.
// A finished word is compared with each stored entry in turn (one row read of
// the word memory, then the compare), then the table is updated or appended
// to and the response register is loaded.
// Reset is synchronous and clears the entry count, so the table starts
// empty; the memories themselves are not cleared.
// A stalled response holds; the engine waits with its next result until
// the response register frees up, while the front end keeps collecting.
`timescale 1ns / 1ps

module word_table_insert_count_lookup #(
  parameter int ENTRIES    = 64,
  parameter int WORD_CHARS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  wtc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output wtc_pkg::rsp_t rsp
);

  // A queued record holds the command, the too-long mark, the category and
  // the zero-filled word.
  localparam int REC_W = (WORD_CHARS - 1) * 8 + 10;

  logic             push;
  logic [REC_W-1:0] push_rec;
  logic             q_full;
  logic             pop;
  logic             q_valid;
  logic [REC_W-1:0] q_rec;

  wtc_front #(.WORD_CHARS(WORD_CHARS), .REC_W(REC_W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_rec  (push_rec),
    .q_full    (q_full)
  );

  wtc_queue #(.REC_W(REC_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_rec    (q_rec)
  );

  // The engine compares stored words in order, so the first match wins.
  wtc_back #(.ENTRIES(ENTRIES), .WORD_CHARS(WORD_CHARS), .REC_W(REC_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* rtl/core/wtc_front.sv */
// ----------------------------------------------------------------------------
// Word table front end
// Collects characters into the incoming word and emits one command record
// per finished word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtc_front #(
  parameter int WORD_CHARS = 32,
  parameter int REC_W      = (WORD_CHARS - 1) * 8 + 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  wtc_pkg::req_t     req,
  output logic              push,
  output logic [REC_W-1:0]  push_rec,
  input  logic              q_full
);

  localparam int ROW_W = (WORD_CHARS - 1) * 8;
  localparam int LW    = $clog2(WORD_CHARS);

  logic [ROW_W-1:0] word;
  logic [ROW_W-1:0] word_next;
  logic [LW-1:0]    len;
  logic [LW-1:0]    len_next;
  logic             too_long;
  logic             too_long_next;
  logic             accept;

  assign req_stall = q_full;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    word_next     = word;
    len_next      = len;
    too_long_next = too_long;
    if (req.char_code != 8'd0) begin
      if (len == LW'(WORD_CHARS - 1)) begin
        too_long_next = 1'b1;
      end else begin
        len_next = len + LW'(1);
      end
      for (int k = 0; k < WORD_CHARS - 1; k++) begin
        if (len == LW'(k)) begin
          word_next[k*8 +: 8] = req.char_code;
        end
      end
    end
  end

  assign push     = accept && req.last_char;
  assign push_rec = {req.command, too_long_next, req.category, word_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      word     <= '0;
      len      <= '0;
      too_long <= 1'b0;
    end else if (accept) begin
      if (req.last_char) begin
        word     <= '0;
        len      <= '0;
        too_long <= 1'b0;
      end else begin
        word     <= word_next;
        len      <= len_next;
        too_long <= too_long_next;
      end
    end
  end

endmodule

/* rtl/core/wtc_queue.sv */
// ----------------------------------------------------------------------------
// Word table command queue
// Two-entry queue between the front end and the search engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtc_queue #(
  parameter int REC_W = 258
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [REC_W-1:0] push_rec,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output logic [REC_W-1:0] q_rec
);

  logic [REC_W-1:0] slot [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_rec   = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/wtc_back.sv */
// ----------------------------------------------------------------------------
// Word table search engine
// Walks the stored words one entry at a time, then updates or appends, or
// reports a miss or a full table, and loads the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtc_back #(
  parameter int ENTRIES    = 64,
  parameter int WORD_CHARS = 32,
  parameter int REC_W      = (WORD_CHARS - 1) * 8 + 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [REC_W-1:0] q_rec,
  output logic             pop,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output wtc_pkg::rsp_t    rsp
);

  localparam int ROW_W = (WORD_CHARS - 1) * 8;
  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_MISS  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [ROW_W-1:0] word_mem [ENTRIES];
  logic [7:0]       freq_mem [ENTRIES];
  logic [7:0]       cat_mem  [ENTRIES];

  logic [2:0]       state;
  logic [IW-1:0]    idx;
  logic [CW-1:0]    count;
  logic             cur_cmd;
  logic [7:0]       cur_cat;
  logic [ROW_W-1:0] cur_word;
  logic [ROW_W-1:0] row_q;
  logic [7:0]       freq_q;
  logic [7:0]       cat_q;
  wtc_pkg::rsp_t    res;

  logic             rec_cmd;
  logic             rec_long;
  logic [7:0]       rec_cat;
  logic [ROW_W-1:0] rec_word;
  logic             table_full;
  logic [IW-1:0]    tail;
  logic [7:0]       upd_freq;
  logic [7:0]       upd_cat;
  logic             do_add;

  assign {rec_cmd, rec_long, rec_cat, rec_word} = q_rec;
  assign pop        = (state == S_IDLE) && q_valid;
  assign table_full = (count >= CW'(ENTRIES));
  assign tail       = count[IW-1:0];
  assign do_add     = (cur_cmd == wtc_pkg::CMD_ADD);
  assign upd_freq   = (do_add && freq_q != wtc_pkg::FREQ_MAX) ? freq_q + 8'd1 : freq_q;
  assign upd_cat    = (do_add && cur_cat != 8'd0) ? cur_cat : cat_q;

  // Word rows: one row read per compare step, one write per append.
  always_ff @(posedge clk) begin
    if (state == S_MISS && do_add) begin
      word_mem[tail] <= cur_word;
    end
    if (state == S_READ) begin
      row_q <= word_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MISS && do_add) begin
      freq_mem[tail] <= 8'd1;
    end else if (state == S_UPD && do_add) begin
      freq_mem[idx] <= upd_freq;
    end
    if (state == S_FETCH) begin
      freq_q <= freq_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MISS && do_add) begin
      cat_mem[tail] <= cur_cat;
    end else if (state == S_UPD && do_add) begin
      cat_mem[idx] <= upd_cat;
    end
    if (state == S_FETCH) begin
      cat_q <= cat_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cmd  <= rec_cmd;
      cur_cat  <= rec_cat;
      cur_word <= rec_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
      res       <= '0;
      rsp       <= '0;
    end else begin
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            idx <= '0;
            if (rec_cmd == wtc_pkg::CMD_ADD && table_full) begin
              res   <= '{wtc_pkg::STAT_FULL, 6'd0, 8'd0, 8'd0, 7'(count)};
              state <= S_DONE;
            end else if (rec_long || count == '0) begin
              state <= S_MISS;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (row_q == cur_word) begin
            state <= S_FETCH;
          end else if (CW'(idx) + CW'(1) < count) begin
            idx   <= idx + IW'(1);
            state <= S_READ;
          end else begin
            state <= S_MISS;
          end
        end
        S_FETCH: begin
          state <= S_UPD;
        end
        S_UPD: begin
          res   <= '{wtc_pkg::STAT_FOUND, 6'(idx), upd_freq, upd_cat, 7'(count)};
          state <= S_DONE;
        end
        S_MISS: begin
          if (do_add) begin
            count <= count + CW'(1);
            res   <= '{wtc_pkg::STAT_NEW, 6'(tail), 8'd1, cur_cat, 7'(count + CW'(1))};
          end else begin
            res <= '{wtc_pkg::STAT_NOTFOUND, 6'd0, 8'd0, 8'd0, 7'(count)};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/wtc_checker.sv */
// ----------------------------------------------------------------------------
// Word table checker
// Port-level checks on the response channel of the word table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wtc_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input wtc_pkg::rsp_t rsp
);

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `ASSERT_SAME(a_full_empty, clk, rst, rsp_valid && rsp.status == wtc_pkg::STAT_FULL, rsp.frequency == 8'd0 && rsp.entry_index == 6'd0)
  `ASSERT_SAME(a_new_freq, clk, rst, rsp_valid && rsp.status == wtc_pkg::STAT_NEW, rsp.frequency == 8'd1 && rsp.entry_count != 7'd0)
  `ASSERT_SAME(a_miss_zero, clk, rst, rsp_valid && rsp.status == wtc_pkg::STAT_NOTFOUND, rsp.frequency == 8'd0 && rsp.entry_category == 8'd0)

endmodule

bind word_table_insert_count_lookup wtc_checker u_wtc_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

/* tb/word_table_insert_count_lookup_tb.sv */
// ----------------------------------------------------------------------------
// Word table testbench
// Sends character requests that build words and adds, counts or looks them
// up. Each response is checked against a behavioral table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_table_insert_count_lookup_tb;

  localparam int ENTRIES    = 64;
  localparam int WORD_CHARS = 32;
  localparam int MAX_LEN    = WORD_CHARS - 1;
  localparam int WATCHDOG   = 20000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  wtc_pkg::req_t  req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  wtc_pkg::rsp_t  rsp;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  word_table_insert_count_lookup #(
    .ENTRIES   (ENTRIES),
    .WORD_CHARS(WORD_CHARS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // Table model. The stored words are kept as byte arrays with a length,
  // which is the same as the zero-filled rows of the block.
  logic [7:0] tbl_word [ENTRIES][MAX_LEN];
  int         tbl_len  [ENTRIES];
  logic [7:0] tbl_freq [ENTRIES];
  logic [7:0] tbl_cat  [ENTRIES];
  int         tbl_count;
  logic [7:0] cur_word [MAX_LEN];
  int         cur_len;
  bit         cur_long;

  wtc_pkg::rsp_t expected_rsps[$];
  int            errors;
  int            idle_cycles;
  int            stall_left;
  bit            no_idle;

  // Index of the first stored entry equal to the word being collected.
  function automatic int search_table();
    bit same;
    if (cur_long) return -1;
    for (int e = 0; e < tbl_count; e++) begin
      same = (tbl_len[e] == cur_len);
      for (int k = 0; k < cur_len; k++)
        if (same && tbl_word[e][k] != cur_word[k]) same = 1'b0;
      if (same) return e;
    end
    return -1;
  endfunction

  // Advances the model by one request and queues the response it causes.
  task automatic predict_table(input wtc_pkg::req_t r);
    wtc_pkg::rsp_t res;
    int            hit;
    res = '0;
    res.status = wtc_pkg::STAT_NOTFOUND;
    if (r.char_code != 8'd0) begin
      if (cur_len < MAX_LEN) begin
        cur_word[cur_len] = r.char_code;
        cur_len++;
      end else begin
        cur_long = 1'b1;
      end
    end
    if (r.last_char) begin
      if (r.command == wtc_pkg::CMD_ADD) begin
        if (tbl_count >= ENTRIES) begin
          res.status = wtc_pkg::STAT_FULL;
        end else begin
          hit = search_table();
          if (hit >= 0) begin
            if (tbl_freq[hit] != wtc_pkg::FREQ_MAX) tbl_freq[hit]++;
            if (r.category != 8'd0) tbl_cat[hit] = r.category;
            res.status = wtc_pkg::STAT_FOUND;
          end else begin
            hit = tbl_count;
            for (int k = 0; k < cur_len; k++) tbl_word[hit][k] = cur_word[k];
            tbl_len[hit]  = cur_len;
            tbl_freq[hit] = 8'd1;
            tbl_cat[hit]  = r.category;
            tbl_count++;
            res.status = wtc_pkg::STAT_NEW;
          end
          res.entry_index    = hit[5:0];
          res.frequency      = tbl_freq[hit];
          res.entry_category = tbl_cat[hit];
        end
      end else begin
        hit = search_table();
        if (hit >= 0) begin
          res.status         = wtc_pkg::STAT_FOUND;
          res.entry_index    = hit[5:0];
          res.frequency      = tbl_freq[hit];
          res.entry_category = tbl_cat[hit];
        end
      end
      res.entry_count = tbl_count[6:0];
      expected_rsps.push_back(res);
      cur_len  = 0;
      cur_long = 1'b0;
    end
  endtask

  // Drives one request, holding it through stalls, with random gaps ahead.
  // Valid stays high from one request to the next unless a gap is taken.
  task automatic send_request(input wtc_pkg::req_t r);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_table(r);
  endtask

  // Sends a whole word from a string, command and category on the last char.
  task automatic send_word(input string s, input logic cmd, input logic [7:0] cat);
    wtc_pkg::req_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.command   = ($urandom_range(0, 1) != 0);
      r.char_code = s[i];
      r.last_char = (i == s.len() - 1);
      r.category  = 8'($urandom_range(0, 255));
      if (r.last_char) begin
        r.command  = cmd;
        r.category = cat;
      end
      send_request(r);
    end
  endtask

  // Random short word from a small alphabet so that repeats are common.
  function automatic string random_word();
    string s;
    int    n;
    s = "";
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) s = {s, string'(8'd97 + 8'($urandom_range(0, 3)))};
    return s;
  endfunction

  // Response side: stall bursts of random length, compare against the
  // oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %p", $time, rsp);
          errors++;
        end else begin
          if (rsp !== expected_rsps[0]) begin
            $display("%0t: response mismatch, expected %p actual %p",
                     $time, expected_rsps[0], rsp);
            errors++;
          end
          void'(expected_rsps.pop_front());
        end
      end
      if (no_idle) begin
        rsp_stall  <= 1'b0;
        stall_left <= 0;
      end else if (rsp_stall) begin
        if (stall_left > 0) stall_left <= stall_left - 1;
        else rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        rsp_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 7);
      end
    end
  end

  // Watchdog: counts cycles with no accepted request or response.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("word_table_insert_count_lookup_tb: FAIL");
      $finish;
    end
  end

  // Directed rows: one request each. When check is set the listed response
  // is compared with the model's prediction at the end of the word.
  typedef struct {
    wtc_pkg::req_t r;
    bit            check;
    wtc_pkg::rsp_t want;
  } stim_row_t;

  initial begin
    stim_row_t     rows[$];
    stim_row_t     row;
    wtc_pkg::req_t r;
    string         w;
    int            n;

    errors   = 0;
    no_idle  = 1'b0;
    tbl_count = 0;
    cur_len  = 0;
    cur_long = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset: lookup of the empty word misses, then it is added.
    row = '{r: '{wtc_pkg::CMD_LOOKUP, 8'd0, 1'b1, 8'd0}, check: 1,
            want: '{wtc_pkg::STAT_NOTFOUND, 6'd0, 8'd0, 8'd0, 7'd0}};
    rows.push_back(row);
    row = '{r: '{wtc_pkg::CMD_ADD, 8'd0, 1'b1, 8'd255}, check: 1,
            want: '{wtc_pkg::STAT_NEW, 6'd0, 8'd1, 8'd255, 7'd1}};
    rows.push_back(row);
    // Single 0xff character, added then counted with category 0, which keeps the stored category.
    row = '{r: '{wtc_pkg::CMD_ADD, 8'd255, 1'b1, 8'd1}, check: 1,
            want: '{wtc_pkg::STAT_NEW, 6'd1, 8'd1, 8'd1, 7'd2}};
    rows.push_back(row);
    row = '{r: '{wtc_pkg::CMD_ADD, 8'd255, 1'b0, 8'd0}, check: 0, want: '0};
    rows.push_back(row);
    row = '{r: '{wtc_pkg::CMD_LOOKUP, 8'd0, 1'b0, 8'd7}, check: 0, want: '0};
    rows.push_back(row);
    row = '{r: '{wtc_pkg::CMD_ADD, 8'd0, 1'b1, 8'd0}, check: 0, want: '0};
    rows.push_back(row);
    row = '{r: '{wtc_pkg::CMD_ADD, 8'd255, 1'b1, 8'd0}, check: 1,
            want: '{wtc_pkg::STAT_FOUND, 6'd1, 8'd3, 8'd1, 7'd2}};
    rows.push_back(row);
    row = '{r: '{wtc_pkg::CMD_LOOKUP, 8'd255, 1'b1, 8'd0}, check: 1,
            want: '{wtc_pkg::STAT_FOUND, 6'd1, 8'd3, 8'd1, 7'd2}};
    rows.push_back(row);
    // Mixed bits in every field, words of two characters.
    row = '{r: '{wtc_pkg::CMD_LOOKUP, 8'h55, 1'b0, 8'haa}, check: 0, want: '0};
    rows.push_back(row);
    row = '{r: '{wtc_pkg::CMD_ADD, 8'haa, 1'b1, 8'h55}, check: 0, want: '0};
    rows.push_back(row);
    row = '{r: '{wtc_pkg::CMD_ADD, 8'h55, 1'b0, 8'h00}, check: 0, want: '0};
    rows.push_back(row);
    row = '{r: '{wtc_pkg::CMD_LOOKUP, 8'haa, 1'b1, 8'hff}, check: 0, want: '0};
    rows.push_back(row);

    foreach (rows[i]) begin
      send_request(rows[i].r);
      if (rows[i].check && expected_rsps[$] != rows[i].want) begin
        $display("%0t: directed row %0d, expected %p actual model %p",
                 $time, i, rows[i].want, expected_rsps[$]);
        errors++;
      end
    end

    // Longest stored word, then one character longer: the long word misses
    // on lookup and is appended as a new entry on add.
    w = "";
    for (int i = 0; i < MAX_LEN; i++) w = {w, "x"};
    send_word(w, wtc_pkg::CMD_ADD, 8'd9);
    send_word(w, wtc_pkg::CMD_LOOKUP, 8'd0);
    send_word({w, "x"}, wtc_pkg::CMD_LOOKUP, 8'd0);
    send_word({w, "x"}, wtc_pkg::CMD_ADD, 8'd3);

    // Saturate one frequency at 255.
    for (int i = 0; i < 256; i++)
      send_word("z", wtc_pkg::CMD_ADD, 8'($urandom_range(0, 1)));

    // Random words, with random zero characters and command noise mid-word.
    for (int i = 0; i < 130; i++) begin
      if (i > 105) no_idle = 1'b1;
      w = random_word();
      if ($urandom_range(0, 15) == 0) begin
        // Long or noisy word built request by request.
        n = $urandom_range(1, 40);
        for (int k = 0; k < n; k++) begin
          r.command   = 1'($urandom_range(0, 1));
          r.char_code = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
          r.last_char = (k == n - 1);
          r.category  = 8'($urandom_range(0, 255));
          send_request(r);
        end
      end else begin
        send_word(w, ($urandom_range(0, 2) == 0) ? wtc_pkg::CMD_LOOKUP : wtc_pkg::CMD_ADD,
                  ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
      end
      // Fill the table about midway so full refusals get exercised.
      if (i == 60)
        while (tbl_count < ENTRIES)
          send_word($sformatf("f%0d", tbl_count), wtc_pkg::CMD_ADD, 8'd4);
    end
    req_valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (2 * ENTRIES + 20) @(posedge clk);
    if (errors == 0) begin
      $display("word_table_insert_count_lookup_tb: PASS");
    end else begin
      $display("word_table_insert_count_lookup_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/wtc_pkg.sv
rtl/core/wtc_front.sv
rtl/core/wtc_queue.sv
rtl/core/wtc_back.sv
rtl/core/word_table_insert_count_lookup.sv
rtl/core/wtc_checker.sv
tb/word_table_insert_count_lookup_tb.sv
